// ===== rtl/cpt_pkg.sv =====
// Shared types, codes and the microcode table of the connection pair table.
// Used by cpt_useq, cpt_dpath and connection_pair_table_top; depends on nothing.
package cpt_pkg;

    // Field widths of the request and result items
    localparam int CMD_W       = 2;
    localparam int KEY_W       = 64;
    localparam int KIND_W      = 3;
    localparam int SLOT_W      = 4;
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 136;

    // A flush reports at most this many close notifications
    localparam int NOTIFY_CAP  = 16;
    localparam int CNT_W       = $clog2(NOTIFY_CAP + 1);

    // Guarded branches per microcode word
    localparam int NARM        = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_OPEN  = 2'd0,
        CMD_CLOSE = 2'd1,
        CMD_FLUSH = 2'd2
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        K_ADDED    = 3'd0,
        K_PRESENT  = 3'd1,
        K_FULL     = 3'd2,
        K_NOTIFY   = 3'd3,
        K_NOTFOUND = 3'd4,
        K_DONE     = 3'd5
    } t_kind;

    // Microprogram steps
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OP_SCAN,
        ST_CL_SCAN,
        ST_FL_OUTER,
        ST_FL_INNER,
        ST_FL_NEXT
    } t_step;

    // Branch conditions tested by the sequencer
    typedef enum logic [3:0] {
        CND_NEVER,
        CND_REQ_OPEN,
        CND_REQ_CLOSE,
        CND_REQ_FLUSH,
        CND_MATCH,
        CND_MATCH_CAP,
        CND_EMPTY,
        CND_OCCUPIED,
        CND_IDX_END,
        CND_OUT_END
    } t_cond;

    // Datapath operations
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_START,
        ACT_INC,
        ACT_FILL,
        ACT_CLEAR,
        ACT_LOAD,
        ACT_NEXT_OUT,
        ACT_WIPE
    } t_act;

    typedef struct packed {
        t_cond cond;
        t_act  act;
        t_step jmp;
        logic  emit;
        t_kind kind;
        logic  use_idx;
        logic  notify;
        logic  last;
    } t_arm;

    // Arms are tested from index 0 up; the default branch runs when none holds
    typedef struct packed {
        t_arm [NARM-1:0] arms;
        t_act            dflt_act;
        t_step           dflt_jmp;
    } t_uword;

    // Sequencer to datapath control
    typedef struct packed {
        t_act  act;
        logic  emit;
        t_kind kind;
        logic  use_idx;
        logic  notify;
        logic  last;
    } t_ctrl;

    // Datapath to sequencer status
    typedef struct packed {
        logic match;
        logic empty;
        logic idx_end;
        logic out_end;
        logic cap_ok;
        logic o_busy;
    } t_status;

    function automatic t_arm f_arm(t_cond c, t_act a, t_step j, logic e, t_kind k,
                                   logic ui, logic nt, logic l);
        t_arm r;
        r.cond    = c;
        r.act     = a;
        r.jmp     = j;
        r.emit    = e;
        r.kind    = k;
        r.use_idx = ui;
        r.notify  = nt;
        r.last    = l;
        return r;
    endfunction

    function automatic t_arm f_nop_arm();
        return f_arm(CND_NEVER, ACT_NONE, ST_IDLE, 1'b0, K_ADDED, 1'b0, 1'b0, 1'b0);
    endfunction

    // Microcode ROM: one word per step
    function automatic t_uword f_urom(t_step s);
        t_uword w;
        w.arms[0]  = f_nop_arm();
        w.arms[1]  = f_nop_arm();
        w.arms[2]  = f_nop_arm();
        w.dflt_act = ACT_NONE;
        w.dflt_jmp = ST_IDLE;
        unique case (s)
            ST_IDLE: begin
                w.arms[0]  = f_arm(CND_REQ_OPEN, ACT_START, ST_OP_SCAN,
                                   1'b0, K_ADDED, 1'b0, 1'b0, 1'b0);
                w.arms[1]  = f_arm(CND_REQ_CLOSE, ACT_START, ST_CL_SCAN,
                                   1'b0, K_ADDED, 1'b0, 1'b0, 1'b0);
                w.arms[2]  = f_arm(CND_REQ_FLUSH, ACT_START, ST_FL_OUTER,
                                   1'b0, K_ADDED, 1'b0, 1'b0, 1'b0);
                w.dflt_act = ACT_NONE;
                w.dflt_jmp = ST_IDLE;
            end
            ST_OP_SCAN: begin
                w.arms[0]  = f_arm(CND_MATCH, ACT_NONE, ST_IDLE,
                                   1'b1, K_PRESENT, 1'b1, 1'b0, 1'b1);
                w.arms[1]  = f_arm(CND_EMPTY, ACT_FILL, ST_IDLE,
                                   1'b1, K_ADDED, 1'b1, 1'b0, 1'b1);
                w.arms[2]  = f_arm(CND_IDX_END, ACT_NONE, ST_IDLE,
                                   1'b1, K_FULL, 1'b0, 1'b0, 1'b1);
                w.dflt_act = ACT_INC;
                w.dflt_jmp = ST_OP_SCAN;
            end
            ST_CL_SCAN: begin
                w.arms[0]  = f_arm(CND_MATCH, ACT_CLEAR, ST_IDLE,
                                   1'b1, K_NOTIFY, 1'b1, 1'b1, 1'b1);
                w.arms[1]  = f_arm(CND_IDX_END, ACT_NONE, ST_IDLE,
                                   1'b1, K_NOTFOUND, 1'b0, 1'b0, 1'b1);
                w.dflt_act = ACT_INC;
                w.dflt_jmp = ST_CL_SCAN;
            end
            ST_FL_OUTER: begin
                w.arms[0]  = f_arm(CND_OCCUPIED, ACT_LOAD, ST_FL_INNER,
                                   1'b0, K_ADDED, 1'b0, 1'b0, 1'b0);
                w.arms[1]  = f_arm(CND_OUT_END, ACT_WIPE, ST_IDLE,
                                   1'b1, K_DONE, 1'b0, 1'b0, 1'b1);
                w.dflt_act = ACT_NEXT_OUT;
                w.dflt_jmp = ST_FL_OUTER;
            end
            ST_FL_INNER: begin
                w.arms[0]  = f_arm(CND_MATCH_CAP, ACT_CLEAR, ST_FL_NEXT,
                                   1'b1, K_NOTIFY, 1'b1, 1'b1, 1'b0);
                w.arms[1]  = f_arm(CND_MATCH, ACT_CLEAR, ST_FL_NEXT,
                                   1'b0, K_NOTIFY, 1'b0, 1'b0, 1'b0);
                w.dflt_act = ACT_INC;
                w.dflt_jmp = ST_FL_INNER;
            end
            ST_FL_NEXT: begin
                w.arms[0]  = f_arm(CND_OUT_END, ACT_WIPE, ST_IDLE,
                                   1'b1, K_DONE, 1'b0, 1'b0, 1'b1);
                w.dflt_act = ACT_NEXT_OUT;
                w.dflt_jmp = ST_FL_OUTER;
            end
            default: begin
                w.dflt_act = ACT_NONE;
                w.dflt_jmp = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/cpt_useq.sv =====
// Microcoded sequencer: step counter, microcode ROM lookup and branch selection.
// Depends on cpt_pkg; drives the control word of cpt_dpath.
module cpt_useq
    import cpt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic [CMD_W-1:0]   i_cmd,
    input  t_status            i_status,
    output logic               o_req_ready,
    output t_ctrl              o_ctrl
);

    t_step  r_step;
    t_step  n_step;
    t_uword w_word;
    t_arm   w_pick;
    logic   w_stall;

    function automatic logic f_cond(t_cond c, t_status st, logic vld, logic [CMD_W-1:0] cmd);
        logic r;
        unique case (c)
            CND_NEVER:     r = 1'b0;
            CND_REQ_OPEN:  r = vld && (cmd == CMD_OPEN);
            CND_REQ_CLOSE: r = vld && (cmd == CMD_CLOSE);
            CND_REQ_FLUSH: r = vld && (cmd == CMD_FLUSH);
            CND_MATCH:     r = st.match;
            CND_MATCH_CAP: r = st.match && st.cap_ok;
            CND_EMPTY:     r = st.empty;
            CND_OCCUPIED:  r = !st.empty;
            CND_IDX_END:   r = st.idx_end;
            CND_OUT_END:   r = st.out_end;
            default:       r = 1'b0;
        endcase
        return r;
    endfunction

    // Fetch the word of this step and pick the first arm whose condition holds
    always_comb begin
        w_word          = f_urom(r_step);
        w_pick          = f_nop_arm();
        w_pick.act      = w_word.dflt_act;
        w_pick.jmp      = w_word.dflt_jmp;
        for (int k = NARM - 1; k >= 0; k--) begin
            if (f_cond(w_word.arms[k].cond, i_status, i_req_valid, i_cmd)) begin
                w_pick = w_word.arms[k];
            end
        end
        w_stall = w_pick.emit && i_status.o_busy;
    end

    // Next step: hold while a result waits for the output register
    always_comb begin
        n_step = w_stall ? r_step : w_pick.jmp;
    end

    // Control word to the datapath
    always_comb begin
        o_ctrl.act     = w_stall ? ACT_NONE : w_pick.act;
        o_ctrl.emit    = w_pick.emit && !w_stall;
        o_ctrl.kind    = w_pick.kind;
        o_ctrl.use_idx = w_pick.use_idx;
        o_ctrl.notify  = w_pick.notify;
        o_ctrl.last    = w_pick.last;
        o_req_ready    = (r_step == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // A result is only loaded when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.emit |-> !i_status.o_busy)
        else $error("result emitted into a busy output register");

    // The program leaves idle only on a request
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_IDLE) && !i_req_valid |=> (r_step == ST_IDLE))
        else $error("sequencer left idle without a request");

endmodule

// ===== rtl/cpt_dpath.sv =====
// Datapath: pair memory, valid bits, scan indexes, search keys and output register.
// Depends on cpt_pkg; executes the control word of cpt_useq.
module cpt_dpath
    import cpt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl                i_ctrl,
    input  logic [KEY_W-1:0]     i_key_a,
    input  logic [KEY_W-1:0]     i_key_b,
    output t_status              o_status,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [KIND_W-1:0]    o_kind,
    output logic [KEY_W-1:0]     o_dest,
    output logic [KEY_W-1:0]     o_src,
    output logic [SLOT_W-1:0]    o_slot,
    output logic                 o_last
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    logic [KEY_W-1:0]       r_mem_a [TABLE_DEPTH];
    logic [KEY_W-1:0]       r_mem_b [TABLE_DEPTH];
    logic [KEY_W-1:0]       r_rd_a;
    logic [KEY_W-1:0]       r_rd_b;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [IW-1:0]          r_idx;
    logic [IW-1:0]          n_idx;
    logic [IW-1:0]          r_outer;
    logic [KEY_W-1:0]       r_ka;
    logic [KEY_W-1:0]       r_kb;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_o_valid;
    logic [KIND_W-1:0]      r_o_kind;
    logic [KEY_W-1:0]       r_o_dest;
    logic [KEY_W-1:0]       r_o_src;
    logic [SLOT_W-1:0]      r_o_slot;
    logic                   r_o_last;
    logic [KEY_W-1:0]       w_a_eff;
    logic [KEY_W-1:0]       w_b_eff;

    // Invalid slots read as an empty pair
    always_comb begin
        w_a_eff = r_valid[r_idx] ? r_rd_a : '0;
        w_b_eff = r_valid[r_idx] ? r_rd_b : '0;
    end

    // Status for the sequencer
    always_comb begin
        o_status.match   = (w_a_eff == r_ka) || (w_b_eff == r_kb);
        o_status.empty   = (w_a_eff == '0);
        o_status.idx_end = (r_idx == LAST_IDX);
        o_status.out_end = (r_outer == LAST_IDX);
        o_status.cap_ok  = (r_cnt < CNT_W'(NOTIFY_CAP));
        o_status.o_busy  = r_o_valid && !i_ready;
    end

    // Next scan index; it also addresses the memory read
    always_comb begin
        unique case (i_ctrl.act)
            ACT_START,
            ACT_LOAD:     n_idx = '0;
            ACT_INC:      n_idx = r_idx + IW'(1);
            ACT_NEXT_OUT: n_idx = r_outer + IW'(1);
            default:      n_idx = r_idx;
        endcase
    end

    // Pair memory: write on fill, registered read at the next index
    always_ff @(posedge i_clk) begin
        if (i_ctrl.act == ACT_FILL) begin
            r_mem_a[r_idx] <= r_ka;
            r_mem_b[r_idx] <= r_kb;
        end
        r_rd_a <= r_mem_a[n_idx];
        r_rd_b <= r_mem_b[n_idx];
    end

    // Valid bits, indexes and notify count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_idx   <= '0;
            r_outer <= '0;
            r_cnt   <= '0;
        end else begin
            r_idx <= n_idx;
            unique case (i_ctrl.act)
                ACT_FILL:     r_valid[r_idx] <= 1'b1;
                ACT_CLEAR:    r_valid[r_idx] <= 1'b0;
                ACT_WIPE:     r_valid <= '0;
                default:      ;
            endcase
            if (i_ctrl.act == ACT_START) begin
                r_outer <= '0;
            end else if (i_ctrl.act == ACT_NEXT_OUT) begin
                r_outer <= r_outer + IW'(1);
            end
            if (i_ctrl.act == ACT_START) begin
                r_cnt <= '0;
            end else if (i_ctrl.emit && (i_ctrl.kind == K_NOTIFY)) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // Search keys: the request's pair, or the pair of the slot being flushed
    always_ff @(posedge i_clk) begin
        if (i_ctrl.act == ACT_START) begin
            r_ka <= i_key_a;
            r_kb <= i_key_b;
        end else if (i_ctrl.act == ACT_LOAD) begin
            r_ka <= w_a_eff;
            r_kb <= w_b_eff;
        end
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_ctrl.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit) begin
            r_o_kind <= i_ctrl.kind;
            r_o_dest <= i_ctrl.notify ? r_kb : '0;
            r_o_src  <= i_ctrl.notify ? r_ka : '0;
            r_o_slot <= i_ctrl.use_idx ? SLOT_W'(r_idx) : '0;
            r_o_last <= i_ctrl.last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_kind  = r_o_kind;
    assign o_dest  = r_o_dest;
    assign o_src   = r_o_src;
    assign o_slot  = r_o_slot;
    assign o_last  = r_o_last;

    // Open only fills a slot that holds no pair
    a_fill_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.act == ACT_FILL) |-> !r_valid[r_idx])
        else $error("fill over an occupied slot");

    // The end of a flush leaves the table empty
    a_wipe_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.act == ACT_WIPE) |=> (r_valid == '0))
        else $error("table not empty after flush");

    // A cleared slot reads as empty afterwards
    a_clear_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.act == ACT_CLEAR) |=> !r_valid[$past(r_idx)])
        else $error("cleared slot still valid");

endmodule

// ===== rtl/connection_pair_table_top.sv =====
// Connection pair table, top level: stream ports, sequencer and datapath.
// Depends on cpt_pkg, cpt_useq and cpt_dpath.
//
// Usage: each request on the s_axis channel carries a command in tuser (open,
// close or flush) and a pair of 64-bit ids in tdata. Open scans the slots in
// order and stops at the first that holds a matching pair or is empty; it fills
// an empty one; close clears the first slot whose first or second id matches
// and returns a notification; flush notifies up to NOTIFY_CAP occupied slots
// in index order and then empties the table. Results leave on m_axis with the
// result kind in tuser and tlast marking the final result of a request.
// Timing: the sequencer steps through one slot per cycle while it is not stalled
// on a busy output register. A flush walks the slots and, per occupied slot,
// runs a search from slot zero for its pair.
// One request is worked at a time; s_axis_tready is high while idle, also
// while the final result still waits in the output register.
// Reset clears the valid bit of every slot at once: the table is empty from
// the first cycle after reset, with no clearing pass.
// When m_axis_tready is low, the output register holds its result and the
// sequencer stalls on the step that produces the next one.
module connection_pair_table_top
    import cpt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // key_a[63:0], key_b[127:64]
    input  logic [CMD_W-1:0]       s_axis_tuser,   // cmd[1:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // notify_dest[63:0], notify_src[127:64],
                                                   // slot[131:128], zero[135:132]
    output logic [KIND_W-1:0]      m_axis_tuser,   // kind[2:0]
    output logic                   m_axis_tlast    // last
);

    t_ctrl             w_ctrl;
    t_status           w_status;
    logic [KEY_W-1:0]  w_dest;
    logic [KEY_W-1:0]  w_src;
    logic [SLOT_W-1:0] w_slot;

    cpt_useq u_useq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_cmd       (s_axis_tuser),
        .i_status    (w_status),
        .o_req_ready (s_axis_tready),
        .o_ctrl      (w_ctrl)
    );

    cpt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_key_a  (s_axis_tdata[KEY_W-1:0]),
        .i_key_b  (s_axis_tdata[2*KEY_W-1:KEY_W]),
        .o_status (w_status),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_kind   (m_axis_tuser),
        .o_dest   (w_dest),
        .o_src    (w_src),
        .o_slot   (w_slot),
        .o_last   (m_axis_tlast)
    );

    // Pack the result fields, lowest field first
    assign m_axis_tdata = {(OUT_TDATA_W - 2*KEY_W - SLOT_W)'(0), w_slot, w_src, w_dest};

endmodule

// ===== bench/tb_connection_pair_table_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for connection_pair_table_top: a scoreboard table tracks the slots
// and checks every result. Depends on cpt_pkg and the connection_pair_table_top RTL.
module tb_connection_pair_table_top;
    import cpt_pkg::*;

    localparam int          TBL_DEPTH     = 16;
    localparam int          WATCHDOG_MAX  = 4000;
    localparam int          SETTLE_CYCLES = 200;
    localparam int          KEY_POOL_N    = 20;
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;
    localparam logic [63:0] KEY_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        t_kind              kind;
        logic [KEY_W-1:0]   dest;
        logic [KEY_W-1:0]   src;
        logic [SLOT_W-1:0]  slot;
        logic               last;
    } t_pair_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;    // key_a[63:0], key_b[127:64]
    logic [CMD_W-1:0]       s_axis_tuser = '0;    // cmd[1:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // notify_dest[63:0], notify_src[127:64],
                                                  // slot[131:128], zero[135:132]
    logic [KIND_W-1:0]      m_axis_tuser;         // kind[2:0]
    logic                   m_axis_tlast;

    // Scoreboard copy of the slot table and the results still owed
    logic [KEY_W-1:0]       pair_first [TBL_DEPTH];
    logic [KEY_W-1:0]       pair_second[TBL_DEPTH];
    t_pair_result           pending_pair_results[$];
    logic [KEY_W-1:0]       key_pool[KEY_POOL_N];
    logic                   pacing_on = 1'b1;
    int                     error_count = 0;
    int                     stalled_cycles = 0;

    connection_pair_table_top #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (!pacing_on || r < 50) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    // Keys mostly from a small pool so that opens and closes collide
    function automatic logic [KEY_W-1:0] pick_pair_key();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80) return key_pool[$urandom_range(KEY_POOL_N - 1)];
        if (r < 95) return {$urandom, $urandom};
        if (r < 98) return KEY_ONES;
        return '0;
    endfunction

    function automatic void queue_result(t_kind kind, logic [KEY_W-1:0] dest, src,
                                         logic [SLOT_W-1:0] slot, logic last);
        t_pair_result res;
        res.kind = kind;
        res.dest = dest;
        res.src  = src;
        res.slot = slot;
        res.last = last;
        pending_pair_results.push_back(res);
    endfunction

    // First slot whose first id equals a or whose second id equals b, else -1
    function automatic int find_pair_slot(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if (pair_first[i] == a || pair_second[i] == b) return i;
        end
        return -1;
    endfunction

    // Update the scoreboard table for one accepted request and queue its results
    function automatic void predict_pair_results(logic [CMD_W-1:0] cmd,
                                                 logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
        int hit;
        int notified;
        logic [KEY_W-1:0] pa;
        logic [KEY_W-1:0] pb;
        case (cmd)
            CMD_OPEN: begin
                for (int i = 0; i < TBL_DEPTH; i++) begin
                    if (pair_first[i] == a || pair_second[i] == b) begin
                        queue_result(K_PRESENT, '0, '0, SLOT_W'(i), 1'b1);
                        return;
                    end
                    if (pair_first[i] == '0) begin
                        pair_first[i]  = a;
                        pair_second[i] = b;
                        queue_result(K_ADDED, '0, '0, SLOT_W'(i), 1'b1);
                        return;
                    end
                end
                queue_result(K_FULL, '0, '0, '0, 1'b1);
            end
            CMD_CLOSE: begin
                hit = find_pair_slot(a, b);
                if (hit < 0) begin
                    queue_result(K_NOTFOUND, '0, '0, '0, 1'b1);
                end else begin
                    pair_first[hit]  = '0;
                    pair_second[hit] = '0;
                    queue_result(K_NOTIFY, b, a, SLOT_W'(hit), 1'b1);
                end
            end
            CMD_FLUSH: begin
                notified = 0;
                for (int i = 0; i < TBL_DEPTH; i++) begin
                    if (pair_first[i] != '0) begin
                        pa  = pair_first[i];
                        pb  = pair_second[i];
                        // search restarts at slot zero and may clear an earlier match
                        hit = find_pair_slot(pa, pb);
                        if (hit < 0) hit = i;
                        pair_first[hit]  = '0;
                        pair_second[hit] = '0;
                        if (notified < NOTIFY_CAP) begin
                            queue_result(K_NOTIFY, pb, pa, SLOT_W'(hit), 1'b0);
                            notified++;
                        end
                    end
                end
                for (int i = 0; i < TBL_DEPTH; i++) begin
                    pair_first[i]  = '0;
                    pair_second[i] = '0;
                end
                queue_result(K_DONE, '0, '0, '0, 1'b1);
            end
            default: ;  // unknown command: no change, no result
        endcase
    endfunction

    // Present one request, hold it until accepted, then maybe idle
    task automatic send_pair_request(input logic [CMD_W-1:0] cmd,
                                     input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_pair_results(cmd, a, b);
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every owed result has come back
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_pair_results.size() != 0) @(posedge i_clk);
    endtask

    // Zero keys, empty-slot close, miss, unknown command and flushes on a sparse table
    task automatic test_empty_table();
        send_pair_request(CMD_OPEN, '0, KEY_ONES);
        send_pair_request(CMD_CLOSE, '0, '0);
        send_pair_request(CMD_CLOSE, KEY_ONES, 64'h5);
        send_pair_request(CMD_UNUSED, KEY_ONES, KEY_ONES);
        send_pair_request(CMD_FLUSH, '0, '0);
        send_pair_request(CMD_OPEN, KEY_ONES, KEY_ONES);
        send_pair_request(CMD_FLUSH, KEY_ONES, KEY_ONES);
    endtask

    // Fill every slot, overflow it, then flush all sixteen pairs after a full drain
    task automatic test_full_table();
        logic [KEY_W-1:0] a;
        logic [KEY_W-1:0] b;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            a = (i == 0) ? KEY_ONES : ({$urandom, $urandom} | 64'h1);
            b = (i == 0) ? 64'h1 : ({$urandom, $urandom} | 64'h2);
            send_pair_request(CMD_OPEN, a, b);
        end
        send_pair_request(CMD_OPEN, {$urandom, $urandom} | 64'h4, {$urandom, $urandom});
        send_pair_request(CMD_OPEN, '0, {$urandom, $urandom});
        send_pair_request(CMD_OPEN, pair_first[5], {$urandom, $urandom});
        wait_results_drained();
        send_pair_request(CMD_FLUSH, '0, '0);
    endtask

    // Random mix; closes mostly aimed at a stored pair. Unknown commands are extra.
    task automatic test_random_traffic(input int count, input int open_pct, input int close_pct);
        int unsigned r;
        int unsigned s;
        logic [KEY_W-1:0] a;
        logic [KEY_W-1:0] b;
        int sent;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(99);
            a = pick_pair_key();
            b = pick_pair_key();
            if (r < open_pct) begin
                send_pair_request(CMD_OPEN, a, b);
                sent++;
            end else if (r < open_pct + close_pct) begin
                s = $urandom_range(TBL_DEPTH - 1);
                case ($urandom_range(3))
                    0: a = pair_first[s];
                    1: b = pair_second[s];
                    2: begin
                        a = pair_first[s];
                        b = pair_second[s];
                    end
                    default: ;
                endcase
                send_pair_request(CMD_CLOSE, a, b);
                sent++;
            end else if (r < 98) begin
                send_pair_request(CMD_FLUSH, a, b);
                sent++;
            end else begin
                send_pair_request(CMD_UNUSED, a, b);
            end
        end
    endtask

    // Result sink: bursts of ready with random stalls between them
    initial begin : sink_pacing
        int unsigned burst;
        int unsigned stall;
        forever begin
            burst = $urandom_range(24, 1);
            m_axis_tready <= 1'b1;
            repeat (burst) @(posedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
            error_count++;
        end
    endtask

    // Compare each accepted result with the oldest owed one
    always @(posedge i_clk) begin
        t_pair_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pair_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got kind %0d tdata %h",
                         $time, m_axis_tuser, m_axis_tdata);
                error_count++;
            end else begin
                want = pending_pair_results.pop_front();
                check_field("kind", 64'(want.kind), 64'(m_axis_tuser));
                check_field("notify_dest", want.dest, m_axis_tdata[63:0]);
                check_field("notify_src", want.src, m_axis_tdata[127:64]);
                check_field("slot", 64'(want.slot), 64'(m_axis_tdata[131:128]));
                check_field("last", 64'(want.last), 64'(m_axis_tlast));
            end
        end
    end

    // Stop the run when neither side moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= WATCHDOG_MAX) begin
            $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_MAX);
            $display("Simulation FAILED");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < TBL_DEPTH; i++) begin
            pair_first[i]  = '0;
            pair_second[i] = '0;
        end
        for (int i = 0; i < KEY_POOL_N; i++) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = KEY_ONES;
        key_pool[1] = 64'h1;
        key_pool[2] = 64'h8000_0000_0000_0000;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_full_table();
        pacing_on = 1'b0;
        test_random_traffic(80, 70, 22);
        pacing_on = 1'b1;
        test_random_traffic(90, 50, 40);
        test_random_traffic(63, 30, 62);

        // Let the last request finish, then give stray results time to show up
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
